// ----- hdl/rba_pkg.sv -----
// Shared types and constants for the region bump allocator.
package rba_pkg;

  localparam int MODE_W   = 3;
  localparam int ID_W     = 4;
  localparam int OFFSET_W = 23;
  localparam int ALIGN_W  = 4;
  localparam int STATUS_W = 2;

  // region count follows the width of the region id field
  localparam int REGION_COUNT = 16;

  localparam logic [OFFSET_W-1:0] LIMIT_RESET = OFFSET_W'(4194304);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 3'd0,
    MODE_GRAB    = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_CLEAR   = 3'd3,
    MODE_USAGE   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NO_REGION = 2'd3
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     region_id;
    logic [OFFSET_W-1:0] request_bytes;
    logic [ALIGN_W-1:0]  align_log2;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] result_offset;
    logic [ID_W-1:0]     granted_region;
  } res_t;

endpackage

// ----- hdl/rba_free_find.sv -----
// Lowest free non-reserved region finder.
module rba_free_find #(
  parameter int REGION_COUNT     = 16,
  parameter int RESERVED_REGIONS = 5,
  localparam int IdxW            = $clog2(REGION_COUNT)
) (
  input  logic [REGION_COUNT-1:0] busy_i,
  output logic                    found_o,
  output logic [IdxW-1:0]         idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    // scan downward so the lowest free region wins
    for (int i = REGION_COUNT - 1; i >= 0; i--) begin
      if (!busy_i[i] && i >= RESERVED_REGIONS) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule

// ----- hdl/region_bump_allocator_top.sv -----
// Region bump allocator: per-region fill offsets and in-use flags, five request modes.
//
// A request is taken when start is high and busy is low; busy is high only in the
// first cycle after reset, so one request can be taken every cycle. The request is
// registered at the accepting edge, then the align-add, limit compare and region
// update run in the following cycle, and the result is registered at the next edge;
// res_valid_o pulses for one cycle. Results come out in request order and cannot be
// held off by the receiver, so they must be taken when strobed. A request sees every
// state change made by the requests before it. region_limit is written through
// cfg_we_i/cfg_wdata_i only while no request is in flight: a user rule, not enforced.
module region_bump_allocator_top
  import rba_pkg::*;
#(
  parameter int RESERVED_REGIONS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                res_valid_o,
  output res_t                res_o,
  input  logic                cfg_we_i,
  input  logic [OFFSET_W-1:0] cfg_wdata_i
);

  localparam int IdxW = $clog2(REGION_COUNT);
  localparam int SumW = OFFSET_W + 2;

  logic                   busy_q;
  logic                   in_valid_q;
  req_t                   req_q;
  logic [OFFSET_W-1:0]    limit_q;
  logic [OFFSET_W-1:0]    fill_q [REGION_COUNT];
  logic [REGION_COUNT-1:0] used_q;
  logic                   res_valid_q;
  res_t                   res_q;
  res_t                   res_d;

  logic                   id_valid;
  logic                   id_reserved;
  logic [IdxW-1:0]        id_idx;
  logic [OFFSET_W-1:0]    fill_rd;
  logic [SumW-1:0]        align_mask;
  logic [SumW-1:0]        start_ofs;
  logic [SumW-1:0]        end_ofs;
  logic                   no_space;

  logic                   free_found;
  logic [IdxW-1:0]        free_idx;

  logic                   wr_en;
  logic [IdxW-1:0]        wr_idx;
  logic [OFFSET_W-1:0]    wr_val;
  logic                   used_set;
  logic                   used_clr;

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  rba_free_find #(
    .REGION_COUNT    (REGION_COUNT),
    .RESERVED_REGIONS(RESERVED_REGIONS)
  ) u_free_find (
    .busy_i (used_q),
    .found_o(free_found),
    .idx_o  (free_idx)
  );

  assign id_valid    = int'(req_q.region_id) < REGION_COUNT;
  assign id_reserved = int'(req_q.region_id) < RESERVED_REGIONS;
  assign id_idx      = IdxW'(req_q.region_id);
  assign fill_rd     = fill_q[id_idx];

  assign align_mask = (SumW'(1) << req_q.align_log2) - SumW'(1);
  assign start_ofs  = (SumW'(fill_rd) + align_mask) & ~align_mask;
  assign end_ofs    = start_ofs + SumW'(req_q.request_bytes);
  assign no_space   = end_ofs > SumW'(limit_q);

  always_comb begin
    res_d    = '{status: ST_BAD_ID, result_offset: '0, granted_region: '0};
    wr_en    = 1'b0;
    wr_idx   = id_idx;
    wr_val   = '0;
    used_set = 1'b0;
    used_clr = 1'b0;
    case (req_q.mode)
      MODE_ALLOC: begin
        if (id_valid) begin
          if (no_space) begin
            res_d.status = ST_NO_SPACE;
          end else begin
            res_d.status        = ST_OK;
            res_d.result_offset = OFFSET_W'(start_ofs);
            wr_en               = 1'b1;
            wr_val              = OFFSET_W'(end_ofs);
          end
        end
      end
      MODE_GRAB: begin
        if (free_found) begin
          res_d.status         = ST_OK;
          res_d.granted_region = ID_W'(free_idx);
          wr_en                = 1'b1;
          wr_idx               = free_idx;
          used_set             = 1'b1;
        end else begin
          res_d.status = ST_NO_REGION;
        end
      end
      MODE_RELEASE: begin
        if (id_valid && !id_reserved) begin
          res_d.status = ST_OK;
          wr_en        = 1'b1;
          used_clr     = 1'b1;
        end
      end
      MODE_CLEAR: begin
        if (id_valid) begin
          res_d.status = ST_OK;
          wr_en        = 1'b1;
        end
      end
      MODE_USAGE: begin
        if (id_valid) begin
          res_d.status        = ST_OK;
          res_d.result_offset = fill_rd;
        end
      end
      default: begin
        res_d.status = ST_BAD_ID;
      end
    endcase
  end

  // control, region state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      limit_q     <= LIMIT_RESET;
      for (int i = 0; i < REGION_COUNT; i++) begin
        fill_q[i] <= '0;
        used_q[i] <= (i < RESERVED_REGIONS);
      end
    end else begin
      busy_q      <= 1'b0;
      in_valid_q  <= start && !busy_q;
      res_valid_q <= in_valid_q;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_valid_q) begin
        if (wr_en) begin
          fill_q[wr_idx] <= wr_val;
        end
        if (used_set) begin
          used_q[wr_idx] <= 1'b1;
        end else if (used_clr) begin
          used_q[wr_idx] <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      req_q <= req_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- dv/region_bump_allocator_top_tb.sv -----
// Self-checking testbench for the region bump allocator: directed and random requests.
`timescale 1ns / 1ps

module region_bump_allocator_top_tb;
  import rba_pkg::*;

  localparam int REGION_N   = 16;
  localparam int RESERVED_N = 5;
  localparam int BYTES_MAX  = 4194304;
  localparam int STALL_MAX  = 2000;
  localparam int PHASE_LEN  = 305;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  req_t                req_i       = '0;
  logic                res_valid_o;
  res_t                res_o;
  logic                cfg_we_i    = 1'b0;
  logic [OFFSET_W-1:0] cfg_wdata_i = '0;

  // allocator state as the testbench sees it
  logic [OFFSET_W-1:0] region_fill [REGION_N];
  logic                region_taken[REGION_N];
  logic [OFFSET_W-1:0] region_limit_q;

  req_t req_backlog[$];
  res_t alloc_replies_due[$];
  logic item_taken   = 1'b0;
  int   gap_pct      = 36;
  int   mismatches   = 0;
  int   stall_cycles = 0;

  region_bump_allocator_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  function automatic res_t serve_request(req_t r);
    res_t        reply;
    logic [63:0] span;
    logic [63:0] cur;
    logic [63:0] base;
    logic [63:0] need;
    logic        found;
    reply = '0;
    reply.status = ST_OK;
    found = 1'b0;
    // a 4-bit id always addresses one of the 16 regions, so no range check here
    case (r.mode)
      MODE_ALLOC: begin
        span = 64'd1 << r.align_log2;
        cur  = 64'(region_fill[r.region_id]);
        base = (cur + span - 64'd1) & ~(span - 64'd1);
        need = base + 64'(r.request_bytes);
        if (need > 64'(region_limit_q)) begin
          reply.status = ST_NO_SPACE;
        end else begin
          region_fill[r.region_id] = need[OFFSET_W-1:0];
          reply.result_offset = base[OFFSET_W-1:0];
        end
      end
      MODE_GRAB: begin
        for (int i = RESERVED_N; i < REGION_N; i++) begin
          if (!found && !region_taken[i]) begin
            found = 1'b1;
            region_taken[i] = 1'b1;
            region_fill[i] = '0;
            reply.granted_region = i[ID_W-1:0];
          end
        end
        if (!found) reply.status = ST_NO_REGION;
      end
      MODE_RELEASE: begin
        if (int'(r.region_id) < RESERVED_N) begin
          reply.status = ST_BAD_ID;
        end else begin
          region_taken[r.region_id] = 1'b0;
          region_fill[r.region_id] = '0;
        end
      end
      MODE_CLEAR: region_fill[r.region_id] = '0;
      MODE_USAGE: reply.result_offset = region_fill[r.region_id];
      default:    reply.status = ST_BAD_ID;
    endcase
    return reply;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.mode = MODE_ALLOC;
    else if (pick < 57) r.mode = MODE_GRAB;
    else if (pick < 69) r.mode = MODE_RELEASE;
    else if (pick < 77) r.mode = MODE_CLEAR;
    else if (pick < 95) r.mode = MODE_USAGE;
    else                r.mode = MODE_W'(MODE_USAGE + $urandom_range(1, 3));
    r.region_id = ID_W'($urandom_range(0, REGION_N - 1));
    pick = $urandom_range(0, 99);
    if (pick < 60)      r.request_bytes = OFFSET_W'($urandom_range(0, 255));
    else if (pick < 85) r.request_bytes = OFFSET_W'($urandom_range(0, 65535));
    else if (pick < 95) r.request_bytes = OFFSET_W'($urandom_range(0, BYTES_MAX));
    else                r.request_bytes = OFFSET_W'(BYTES_MAX - $urandom_range(0, 1));
    // alignments above 4 KiB are rare but legal
    if ($urandom_range(0, 99) < 5) r.align_log2 = ALIGN_W'($urandom_range(13, 15));
    else                           r.align_log2 = ALIGN_W'($urandom_range(0, 12));
    return r;
  endfunction

  task automatic push_req(logic [MODE_W-1:0] mode, int id, int bytes, int lg);
    req_t r;
    r.mode          = mode;
    r.region_id     = ID_W'(id);
    r.request_bytes = OFFSET_W'(bytes);
    r.align_log2    = ALIGN_W'(lg);
    req_backlog.push_back(r);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) req_backlog.push_back(random_request());
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || start || alloc_replies_due.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_limit(logic [OFFSET_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    region_limit_q = value;
  endtask

  // driver: a new item goes out once the previous one was taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        req_i <= req_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check each strobed result
  always @(posedge clk_i) begin : mon
    res_t want;
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (res_valid_o) begin
        if (alloc_replies_due.size() == 0) begin
          flag_mismatch("result with nothing outstanding", 32'(res_o), '0);
        end else begin
          want = alloc_replies_due.pop_front();
          if (res_o.status !== want.status)
            flag_mismatch("status", 32'(res_o.status), 32'(want.status));
          if (res_o.result_offset !== want.result_offset)
            flag_mismatch("result_offset", 32'(res_o.result_offset),
                          32'(want.result_offset));
          if (res_o.granted_region !== want.granted_region)
            flag_mismatch("granted_region", 32'(res_o.granted_region),
                          32'(want.granted_region));
        end
      end
      if (start && !busy) alloc_replies_due.push_back(serve_request(req_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [OFFSET_W-1:0] limits[6];
    region_limit_q = LIMIT_RESET;
    for (int i = 0; i < REGION_N; i++) begin
      region_fill[i]  = '0;
      region_taken[i] = (i < RESERVED_N);
    end
    limits[0] = '0;
    limits[1] = OFFSET_W'(4096);
    limits[2] = OFFSET_W'(BYTES_MAX - 1);
    limits[3] = OFFSET_W'($urandom_range(1, BYTES_MAX));
    limits[4] = OFFSET_W'(300);
    limits[5] = LIMIT_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_limit(LIMIT_RESET);

    push_req(MODE_USAGE, 0, 0, 0);
    push_req(MODE_ALLOC, 0, 0, 0);
    push_req(MODE_ALLOC, 5, BYTES_MAX, 0);       // fills region to the limit
    push_req(MODE_ALLOC, 5, 1, 4);               // one byte too many
    push_req(MODE_USAGE, 5, 0, 0);
    push_req(MODE_ALLOC, 15, 3, 0);
    push_req(MODE_ALLOC, 15, 1, 15);             // largest alignment
    push_req(MODE_ALLOC, 15, 'h2AAAAA, 12);
    push_req(MODE_ALLOC, 3, 'h155555, 1);        // busy reserved region still allocates
    push_req(MODE_RELEASE, 0, 0, 0);             // reserved
    push_req(MODE_RELEASE, 4, 0, 0);
    push_req(MODE_RELEASE, 10, 0, 0);            // already free
    push_req(MODE_CLEAR, 5, 0, 0);
    push_req(MODE_USAGE, 5, 0, 0);
    push_req(MODE_W'(MODE_USAGE + 1), 7, 5, 3);
    push_req(MODE_W'(MODE_USAGE + 3), 15, BYTES_MAX, 15);
    // claim every free region, then one more with none left
    for (int i = RESERVED_N; i <= REGION_N; i++) push_req(MODE_GRAB, 0, 0, 0);
    push_req(MODE_RELEASE, 15, 0, 0);
    push_req(MODE_GRAB, 0, 0, 0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      gap_pct = (p == 2) ? 0 : 36;
      if (p == 3) begin
        // stop mid-phase until every result is back
        queue_random(PHASE_LEN / 2);
        wait_drained();
        queue_random(PHASE_LEN - PHASE_LEN / 2);
      end else begin
        queue_random(PHASE_LEN);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (alloc_replies_due.size() != 0)
      flag_mismatch("results never returned", alloc_replies_due.size(), '0);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rba_pkg.sv
hdl/rba_free_find.sv
hdl/region_bump_allocator_top.sv
dv/region_bump_allocator_top_tb.sv
